[rtl/core/mcr_pkg.sv]
`default_nettype none

package mcr_pkg;

   localparam int COORD_BITS = 12;
   localparam int CFG_BITS   = 13;
   localparam int ADDR_BITS  = 24;
   localparam int COLOR_BITS = 32;
   localparam int OFS_BITS   = COORD_BITS + 1;
   localparam int DEC_BITS   = COORD_BITS + 6;
   localparam int PT_BITS    = COORD_BITS + 2;
   localparam int PROD_BITS  = COORD_BITS + CFG_BITS;
   localparam int IDX_BITS   = 3;

   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CFG_BITS-1:0] COORD_SPAN = CFG_BITS'(1 << COORD_BITS);
   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

   localparam logic [IDX_BITS-1:0] IDX_FINAL = '1;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

   typedef struct packed {
      logic                  op;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
      logic [COORD_BITS-1:0] radius;
      logic [COLOR_BITS-1:0] color;
   } req_type;

   typedef struct packed {
      logic                  visible;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [ADDR_BITS-1:0]  pixel_address;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  last;
      logic                  finished;
   } rsp_type;

   // one queued step: either the eight points of a circle step or a
   // single "nothing in progress" marker
   typedef struct packed {
      logic                  idle;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
      logic [OFS_BITS-1:0]   ofs_a;
      logic [OFS_BITS-1:0]   ofs_b;
      logic [COLOR_BITS-1:0] color;
      logic                  done;
   } job_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] width;
      logic [CFG_BITS-1:0] height;
   } screen_type;

endpackage

`default_nettype wire

[rtl/core/midpoint_circle_rasterizer.sv]
// Throughput: one point per cycle from the point generator and its single row-pitch
// multiplier, while the rsp side does not stall the pipeline; the step queue lets
// requests run ahead of the points.
// Reset: synchronous, active high; clears circle state, queue and pipeline, screen 640x480.
`default_nettype none

module midpoint_circle_rasterizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  mcr_pkg::req_type                          req_data,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output mcr_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mcr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mcr_pkg::CFG_BITS-1:0]         csr_data
);
   import mcr_pkg::*;

   screen_type screen_ff, screen_in;
   logic       accept;
   logic       job_push, job_pop, job_empty, job_full;
   job_type    push_job, head_job;

   assign csr_ready = 1'b1;
   assign req_full  = job_full;
   assign accept    = req_push && !job_full;

   always_comb begin
      screen_in = screen_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SCREEN_WIDTH:  screen_in.width  = csr_data;
            REG_SCREEN_HEIGHT: screen_in.height = csr_data;
            default: screen_in = screen_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff.width  <= WIDTH_RESET;
         screen_ff.height <= HEIGHT_RESET;
      end else begin
         screen_ff <= screen_in;
      end
   end

   mcr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .job_push (job_push),
      .job      (push_job)
   );

   mcr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .head      (head_job),
      .empty     (job_empty)
   );

   mcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .screen    (screen_ff),
      .job       (head_job),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp       (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire

[rtl/core/mcr_front.sv]
`default_nettype none

module mcr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  mcr_pkg::req_type      req,
   output logic                  job_push,
   output mcr_pkg::job_type      job
);
   import mcr_pkg::*;

   logic [COORD_BITS-1:0] center_col_ff, center_col_in;
   logic [COORD_BITS-1:0] center_row_ff, center_row_in;
   logic [OFS_BITS-1:0]   offset_a_ff, offset_a_in;
   logic [OFS_BITS-1:0]   offset_b_ff, offset_b_in;
   logic [DEC_BITS-1:0]   decision_ff, decision_in;
   logic [COLOR_BITS-1:0] draw_color_ff, draw_color_in;
   logic                  active_ff, active_in;

   logic signed [DEC_BITS-1:0] a_ext, b_ext, dec_next;
   logic signed [OFS_BITS-1:0] a_next, b_next;
   logic                       step_done;

   always_comb begin
      a_ext = DEC_BITS'($signed(offset_a_ff));
      b_ext = DEC_BITS'($signed(offset_b_ff));
      if ($signed(decision_ff) < 0) begin
         dec_next = $signed(decision_ff) + (a_ext <<< 2) + DEC_BITS'(6);
         b_next   = $signed(offset_b_ff);
      end else begin
         dec_next = $signed(decision_ff) + ((a_ext - b_ext) <<< 2) + DEC_BITS'(10);
         b_next   = $signed(offset_b_ff) - OFS_BITS'(1);
      end
      a_next    = $signed(offset_a_ff) + OFS_BITS'(1);
      step_done = a_next > b_next;
   end

   always_comb begin
      center_col_in = center_col_ff;
      center_row_in = center_row_ff;
      offset_a_in   = offset_a_ff;
      offset_b_in   = offset_b_ff;
      decision_in   = decision_ff;
      draw_color_in = draw_color_ff;
      active_in     = active_ff;
      if (accept) begin
         if (req.op == OP_START) begin
            center_col_in = req.center_x;
            center_row_in = req.center_y;
            draw_color_in = req.color;
            offset_a_in   = '0;
            offset_b_in   = {1'b0, req.radius};
            decision_in   = DEC_BITS'(3) - (DEC_BITS'(req.radius) << 1);
            active_in     = 1'b1;
         end else if (active_ff) begin
            offset_a_in = a_next;
            offset_b_in = b_next;
            decision_in = dec_next;
            active_in   = !step_done;
         end
      end
   end

   always_comb begin
      job_push     = accept && (req.op == OP_STEP);
      job.idle     = !active_ff;
      job.center_x = center_col_ff;
      job.center_y = center_row_ff;
      job.ofs_a    = offset_a_ff;
      job.ofs_b    = offset_b_ff;
      job.color    = draw_color_ff;
      job.done     = step_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff <= '0;
         center_row_ff <= '0;
         offset_a_ff   <= '0;
         offset_b_ff   <= '0;
         decision_ff   <= '0;
         draw_color_ff <= '0;
         active_ff     <= 1'b0;
      end else begin
         center_col_ff <= center_col_in;
         center_row_ff <= center_row_in;
         offset_a_ff   <= offset_a_in;
         offset_b_ff   <= offset_b_in;
         decision_ff   <= decision_in;
         draw_color_ff <= draw_color_in;
         active_ff     <= active_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/mcr_queue.sv]
`default_nettype none

module mcr_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  mcr_pkg::job_type      push_data,
   output logic                  full,
   input  wire logic             pop,
   output mcr_pkg::job_type      head,
   output logic                  empty
);
   import mcr_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   job_type entry_ff [DEPTH];

   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full    = (count_ff == CNT_FULL);
      empty   = (count_ff == '0);
      head    = entry_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/mcr_back.sv]
`default_nettype none

module mcr_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  mcr_pkg::screen_type   screen,
   input  mcr_pkg::job_type      job,
   input  wire logic             job_empty,
   output logic                  job_pop,
   output mcr_pkg::rsp_type      rsp,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop
);
   import mcr_pkg::*;

   // point generator
   logic                busy_ff, busy_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   job_type             cur_ff, cur_in;

   // stage 1: clipped point, stage 2: row product, then output register
   logic                  s1_valid_ff, s1_valid_in;
   rsp_type               s1_ff, s1_in;
   logic                  s2_valid_ff, s2_valid_in;
   rsp_type               s2_ff;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic out_ready, s2_ready, s1_ready;
   logic emit, gen_last, load;

   logic signed [PT_BITS-1:0] cx, cy, ua, ub, du, dv, px, py, lim_w, lim_h;
   logic [CFG_BITS-1:0]       clip_w, clip_h;
   logic                      vis;

   always_comb begin
      out_ready = !out_valid_ff || rsp_pop;
      s2_ready  = !s2_valid_ff || out_ready;
      s1_ready  = !s1_valid_ff || s2_ready;

      emit     = busy_ff && s1_ready;
      gen_last = cur_ff.idle || (idx_ff == IDX_FINAL);
      load     = !busy_ff || (emit && gen_last);
      job_pop  = load && !job_empty;

      busy_in = busy_ff;
      idx_in  = idx_ff;
      cur_in  = cur_ff;
      if (load) begin
         busy_in = !job_empty;
         idx_in  = '0;
         cur_in  = job;
      end else if (emit) begin
         idx_in = idx_ff + IDX_BITS'(1);
      end
   end

   // index bit 2 swaps the offsets, bit 1 mirrors x, bit 0 mirrors y
   always_comb begin
      cx = PT_BITS'($signed({1'b0, cur_ff.center_x}));
      cy = PT_BITS'($signed({1'b0, cur_ff.center_y}));
      ua = PT_BITS'($signed(cur_ff.ofs_a));
      ub = PT_BITS'($signed(cur_ff.ofs_b));
      du = idx_ff[2] ? ub : ua;
      dv = idx_ff[2] ? ua : ub;
      px = idx_ff[1] ? cx - du : cx + du;
      py = idx_ff[0] ? cy - dv : cy + dv;

      clip_w = (screen.width  > COORD_SPAN) ? COORD_SPAN : screen.width;
      clip_h = (screen.height > COORD_SPAN) ? COORD_SPAN : screen.height;
      lim_w  = PT_BITS'($signed({1'b0, clip_w}));
      lim_h  = PT_BITS'($signed({1'b0, clip_h}));
      vis    = !cur_ff.idle && (px >= 0) && (py >= 0) && (px < lim_w) && (py < lim_h);

      s1_in.visible       = vis;
      s1_in.pixel_x       = vis ? px[COORD_BITS-1:0] : '0;
      s1_in.pixel_y       = vis ? py[COORD_BITS-1:0] : '0;
      s1_in.pixel_address = '0;
      s1_in.pixel_color   = vis ? cur_ff.color : '0;
      s1_in.last          = gen_last;
      s1_in.finished      = cur_ff.idle || ((idx_ff == IDX_FINAL) && cur_ff.done);

      s1_valid_in = s1_ready ? emit : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_ready ? s2_valid_ff : out_valid_ff;

      prod_in = PROD_BITS'(s1_ff.pixel_y * screen.width);

      out_in = s2_ff;
      out_in.pixel_address = ADDR_BITS'(prod_ff + PROD_BITS'(s2_ff.pixel_x));
   end

   assign rsp       = out_ff;
   assign rsp_empty = !out_valid_ff;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff   <= s1_ff;
         prod_ff <= prod_in;
      end
      if (out_ready) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire
